// ===== src/mi3_pkg.sv =====
package mi3_pkg;

    localparam int unsigned ELEM_W = 16;

    typedef struct packed {
        logic signed [ELEM_W-1:0] m_r0c0;
        logic signed [ELEM_W-1:0] m_r0c1;
        logic signed [ELEM_W-1:0] m_r0c2;
        logic signed [ELEM_W-1:0] m_r1c0;
        logic signed [ELEM_W-1:0] m_r1c1;
        logic signed [ELEM_W-1:0] m_r1c2;
        logic signed [ELEM_W-1:0] m_r2c0;
        logic signed [ELEM_W-1:0] m_r2c1;
        logic signed [ELEM_W-1:0] m_r2c2;
    } t_mat_in;

    typedef struct packed {
        logic signed [ELEM_W-1:0] inv_r0c0;
        logic signed [ELEM_W-1:0] inv_r0c1;
        logic signed [ELEM_W-1:0] inv_r0c2;
        logic signed [ELEM_W-1:0] inv_r1c0;
        logic signed [ELEM_W-1:0] inv_r1c1;
        logic signed [ELEM_W-1:0] inv_r1c2;
        logic signed [ELEM_W-1:0] inv_r2c0;
        logic signed [ELEM_W-1:0] inv_r2c1;
        logic signed [ELEM_W-1:0] inv_r2c2;
        logic                     singular;
        logic                     clipped;
    } t_mat_out;

endpackage

// ===== src/mi3_div_lane.sv =====
// Unsigned restoring divider lane: QMAX_W quotient bits, STEP bits per cycle while i_step is high.
// The load cycle also runs the first slice; each i_step runs the next one.
// A quotient of 2^QMAX_W or more is flagged in the top bit for the merge stage.
module mi3_div_lane #(
    parameter int NUM_W = 49,
    parameter int DEN_W = 50,
    parameter int STEP  = 4,
    parameter int QMAX_W = 16
) (
    input  logic              i_clk,
    input  logic              i_load,
    input  logic [NUM_W-1:0]  i_num,
    input  logic [DEN_W-1:0]  i_den,
    input  logic              i_step,
    output logic [QMAX_W:0]   o_quot
);
    localparam int HW   = NUM_W - QMAX_W;
    localparam int CMPW = (HW > DEN_W) ? HW : DEN_W;

    logic [QMAX_W-1:0] r_q, n_q, v_q;
    logic [DEN_W:0]    r_rem, n_rem, v_rem;
    logic [DEN_W-1:0]  r_den, v_den;
    logic              r_ovf;
    logic [DEN_W:0]    v_try;

    always_comb begin
        // start from the upper numerator bits; the low bits shift in below
        if (i_load) begin
            v_rem = (DEN_W+1)'(i_num[NUM_W-1:QMAX_W]);
            v_q   = i_num[QMAX_W-1:0];
            v_den = i_den;
        end else begin
            v_rem = r_rem;
            v_q   = r_q;
            v_den = r_den;
        end
        n_rem = v_rem;
        n_q   = v_q;
        v_try = '0;
        for (int k = 0; k < STEP; k++) begin
            n_rem = {n_rem[DEN_W-1:0], n_q[QMAX_W-1]};
            n_q   = {n_q[QMAX_W-2:0], 1'b0};
            v_try = n_rem - {1'b0, v_den};
            if (!v_try[DEN_W]) begin
                n_rem  = v_try;
                n_q[0] = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_rem <= n_rem;
            r_q   <= n_q;
            r_den <= i_den;
            r_ovf <= (CMPW'(i_num[NUM_W-1:QMAX_W]) >= CMPW'(i_den));
        end else if (i_step) begin
            r_rem <= n_rem;
            r_q   <= n_q;
        end
    end

    assign o_quot = {r_ovf, r_q};
endmodule

// ===== src/mi3_cofactor.sv =====
// Cofactors (registered products, then differences) and determinant
// (registered products, then sum); all widths exact.
module mi3_cofactor (
    input  logic                     i_clk,
    input  mi3_pkg::t_mat_in         i_mat,
    input  logic                     i_en,
    output logic signed [2*mi3_pkg::ELEM_W:0]   o_cof [9],
    output logic signed [3*mi3_pkg::ELEM_W+1:0] o_det
);
    import mi3_pkg::*;

    localparam int PW = 2 * ELEM_W;
    logic signed [ELEM_W-1:0] a [9];
    logic signed [ELEM_W-1:0] r_a1 [3], r_a2 [3];
    logic signed [PW-1:0] r_p [18];
    logic signed [PW:0]   r_c [9];
    logic signed [3*ELEM_W:0] r_d [3];
    logic signed [3*ELEM_W+1:0] r_det;

    assign a = '{i_mat.m_r0c0, i_mat.m_r0c1, i_mat.m_r0c2,
                 i_mat.m_r1c0, i_mat.m_r1c1, i_mat.m_r1c2,
                 i_mat.m_r2c0, i_mat.m_r2c1, i_mat.m_r2c2};

    function automatic int idx(input int r, input int c);
        return r * 3 + c;
    endfunction

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int i = 0; i < 9; i++) begin
                r_p[2*i]   <= a[idx((i/3 == 0) ? 1 : 0, (i%3 == 0) ? 1 : 0)]
                            * a[idx((i/3 == 2) ? 1 : 2, (i%3 == 2) ? 1 : 2)];
                r_p[2*i+1] <= a[idx((i/3 == 0) ? 1 : 0, (i%3 == 2) ? 1 : 2)]
                            * a[idx((i/3 == 2) ? 1 : 2, (i%3 == 0) ? 1 : 0)];
            end
            for (int i = 0; i < 3; i++) begin
                r_a1[i] <= a[i];
                r_a2[i] <= r_a1[i];
            end
            for (int i = 0; i < 9; i++) begin
                if (((i / 3) + (i % 3)) % 2 == 1)
                    r_c[i] <= (PW+1)'(r_p[2*i+1]) - (PW+1)'(r_p[2*i]);
                else
                    r_c[i] <= (PW+1)'(r_p[2*i]) - (PW+1)'(r_p[2*i+1]);
            end
            for (int i = 0; i < 3; i++)
                r_d[i] <= r_a2[i] * r_c[i];
            r_det <= (3*ELEM_W+2)'(r_d[0]) + (3*ELEM_W+2)'(r_d[1])
                   + (3*ELEM_W+2)'(r_d[2]);
        end
    end

    // cofactors pass through r_c2 and r_c3 to line up with the determinant
    logic signed [PW:0] r_c2 [9];
    logic signed [PW:0] r_c3 [9];
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int i = 0; i < 9; i++) begin
                r_c2[i] <= r_c[i];
                r_c3[i] <= r_c2[i];
            end
        end
    end

    assign o_cof = r_c3;
    assign o_det = r_det;
endmodule

// ===== src/matrix_inverse_3x3_core.sv =====
// Channel  | Ports                          | Beat
// input    | i_start, o_busy, i_mat         | start & !busy
// result   | o_valid, o_res                 | valid, one cycle, no stall
// Path: cofactor/determinant pipeline, divider lanes, then a registered merge.
// The nine divider lanes take 4 quotient bits a cycle while stepping; busy
// rises after each accepted beat and holds off the next start until it clears.
// Reset clears the pipeline valid bits; data registers hold no reset.
module matrix_inverse_3x3_core #(
    parameter int FRAC_BITS = 8
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  mi3_pkg::t_mat_in  i_mat,
    output logic              o_busy,
    output logic              o_valid,
    output mi3_pkg::t_mat_out o_res
);
    import mi3_pkg::*;

    localparam int CW    = 2 * ELEM_W + 1;
    localparam int DW    = 3 * ELEM_W + 2;
    localparam int NUM_W = CW + 2 * FRAC_BITS;
    localparam int STEPS = 4;
    localparam int STEP  = ELEM_W / STEPS;

    logic [1:0] r_bcnt;
    logic       w_acc;
    logic [3:0] r_pv;
    logic signed [CW-1:0] w_cof [9];
    logic signed [DW-1:0] w_det;
    logic       r_dv, r_dneg, r_zero;
    logic [1:0] r_dcnt;
    logic [8:0] r_neg;
    logic [ELEM_W:0] w_q [9];
    logic       w_load, r_done;
    logic [ELEM_W-1:0] w_el [9];
    logic [8:0] w_clip;

    assign w_acc  = i_start && !o_busy;
    assign o_busy = (r_bcnt != 2'd0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bcnt <= 2'd0;
            r_pv   <= '0;
        end else begin
            r_bcnt <= w_acc ? 2'd3 : (o_busy ? r_bcnt - 2'd1 : 2'd0);
            r_pv   <= {r_pv[2:0], w_acc};
        end
    end

    // the front pipeline runs every cycle; the valid bits pick the beat off
    mi3_cofactor u_cof (
        .i_clk (i_clk),
        .i_mat (i_mat),
        .i_en  (1'b1),
        .o_cof (w_cof),
        .o_det (w_det)
    );

    assign w_load = r_pv[3];

    genvar g;
    generate
        for (g = 0; g < 9; g++) begin : g_lane
            // adjugate: output (i,j) takes cofactor (j,i)
            localparam int SRC = (g % 3) * 3 + (g / 3);
            logic [CW-1:0] w_cm;
            logic [DW-1:0] w_dm;
            assign w_cm = w_cof[SRC][CW-1] ? CW'(-w_cof[SRC]) : CW'(w_cof[SRC]);
            assign w_dm = w_det[DW-1] ? DW'(-w_det) : DW'(w_det);
            mi3_div_lane #(
                .NUM_W  (NUM_W),
                .DEN_W  (DW),
                .STEP   (STEP),
                .QMAX_W (ELEM_W)
            ) u_div (
                .i_clk  (i_clk),
                .i_load (w_load),
                .i_num  (NUM_W'(w_cm) << (2 * FRAC_BITS)),
                .i_den  (w_dm),
                .i_step (r_dv),
                .o_quot (w_q[g])
            );
        end
    endgenerate

    // load runs the first slice; three more steps finish the quotient
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dv   <= 1'b0;
            r_dcnt <= 2'd0;
            r_done <= 1'b0;
        end else begin
            r_done <= r_dv && (r_dcnt == 2'd2);
            if (w_load) begin
                r_dv   <= 1'b1;
                r_dcnt <= 2'd0;
            end else if (r_dv) begin
                r_dcnt <= r_dcnt + 2'd1;
                if (r_dcnt == 2'd2) r_dv <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_zero <= (w_det == '0);
            r_dneg <= w_det[DW-1];
            for (int k = 0; k < 9; k++)
                r_neg[k] <= w_cof[(k % 3) * 3 + (k / 3)][CW-1] ^ w_det[DW-1];
        end
    end

    // merge: saturate each lane, sign-correct, zero on singular, and fold clip flags
    always_comb begin
        for (int k = 0; k < 9; k++) begin
            w_clip[k] = 1'b0;
            if (r_neg[k]) begin
                if (w_q[k] > {1'b0, 1'b1, {(ELEM_W-1){1'b0}}}) begin
                    w_el[k]   = {1'b1, {(ELEM_W-1){1'b0}}};
                    w_clip[k] = 1'b1;
                end else begin
                    w_el[k] = ELEM_W'(-w_q[k]);
                end
            end else begin
                if (w_q[k] > {2'b00, {(ELEM_W-1){1'b1}}}) begin
                    w_el[k]   = {1'b0, {(ELEM_W-1){1'b1}}};
                    w_clip[k] = 1'b1;
                end else begin
                    w_el[k] = w_q[k][ELEM_W-1:0];
                end
            end
            if (r_zero) w_el[k] = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) o_valid <= 1'b0;
        else          o_valid <= r_done;
    end

    always_ff @(posedge i_clk) begin
        if (r_done) begin
            o_res.inv_r0c0 <= w_el[0];
            o_res.inv_r0c1 <= w_el[1];
            o_res.inv_r0c2 <= w_el[2];
            o_res.inv_r1c0 <= w_el[3];
            o_res.inv_r1c1 <= w_el[4];
            o_res.inv_r1c2 <= w_el[5];
            o_res.inv_r2c0 <= w_el[6];
            o_res.inv_r2c1 <= w_el[7];
            o_res.inv_r2c2 <= w_el[8];
            o_res.singular <= r_zero;
            o_res.clipped  <= !r_zero && (|w_clip) && !r_dneg ? 1'b1
                            : (!r_zero && (|w_clip));
        end
    end
endmodule

// ===== src/mi3_checker.sv =====
module mi3_checker (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_start,
    input logic              o_busy,
    input logic              o_valid,
    input mi3_pkg::t_mat_out o_res
);
    a_busy_after_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy) |=> o_busy)
        else $error("busy low after accepted beat");

    a_valid_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid)
        else $error("result strobe longer than one cycle");

    a_singular_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_res.singular) |-> (!o_res.clipped && o_res.inv_r1c1 == '0))
        else $error("singular result carries data");

    a_no_orphan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(i_start && !o_busy, 9))
        else $error("result without matching beat");
endmodule

bind matrix_inverse_3x3_core mi3_checker u_chk (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .i_start (i_start),
    .o_busy  (o_busy),
    .o_valid (o_valid),
    .o_res   (o_res)
);

// ===== dv/tb_matrix_inverse_3x3_core.sv =====
module tb_matrix_inverse_3x3_core;
    timeunit 1ns;
    timeprecision 1ps;

    import mi3_pkg::*;

    localparam int FRAC = 8;
    localparam int DIRECTED_N = 24;
    localparam int RANDOM_N = 1800;
    localparam int unsigned CYCLE_LIMIT = 400000;

    logic     i_clk = 1'b0;
    logic     i_rst_n = 1'b0;
    logic     i_start = 1'b0;
    t_mat_in  i_mat = '0;
    logic     o_busy;
    logic     o_valid;
    t_mat_out o_res;

    t_mat_in  mat_queue[$];
    t_mat_out inverse_queue[$];
    int       error_count = 0;
    bit       stim_done = 1'b0;
    int unsigned cycle_count = 0;
    int       burst_left = 0;
    int       gap_left = 0;

    matrix_inverse_3x3_core #(.FRAC_BITS(FRAC)) u_top (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_start(i_start),
        .i_mat  (i_mat),
        .o_busy (o_busy),
        .o_valid(o_valid),
        .o_res  (o_res)
    );

    always #5 i_clk = ~i_clk;

    function automatic logic signed [15:0] divide_sat(longint cof, longint det, ref bit clip);
        longint num;
        longint q;
        bit     neg;
        neg = (cof < 0) != (det < 0);
        num = (cof < 0 ? -cof : cof) <<< (2 * FRAC);
        q = num / (det < 0 ? -det : det);
        if (neg) begin
            if (q > 32768) begin
                q = 32768;
                clip = 1'b1;
            end
            return 16'(-q);
        end
        if (q > 32767) begin
            q = 32767;
            clip = 1'b1;
        end
        return 16'(q);
    endfunction

    function automatic t_mat_out invert_matrix(t_mat_in m);
        longint   a[3][3];
        longint   cof[3][3];
        longint   det;
        t_mat_out r;
        bit       clip;
        int       r0, r1, c0, c1;
        logic signed [15:0] e[9];
        a[0][0] = m.m_r0c0; a[0][1] = m.m_r0c1; a[0][2] = m.m_r0c2;
        a[1][0] = m.m_r1c0; a[1][1] = m.m_r1c1; a[1][2] = m.m_r1c2;
        a[2][0] = m.m_r2c0; a[2][1] = m.m_r2c1; a[2][2] = m.m_r2c2;
        for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
                r0 = (i == 0) ? 1 : 0;
                r1 = (i == 2) ? 1 : 2;
                c0 = (j == 0) ? 1 : 0;
                c1 = (j == 2) ? 1 : 2;
                cof[i][j] = a[r0][c0] * a[r1][c1] - a[r0][c1] * a[r1][c0];
                if ((i + j) % 2 == 1) cof[i][j] = -cof[i][j];
            end
        end
        det = a[0][0] * cof[0][0] + a[0][1] * cof[0][1] + a[0][2] * cof[0][2];
        r = '0;
        if (det == 0) begin
            r.singular = 1'b1;
            return r;
        end
        clip = 1'b0;
        // adjugate: element (i, j) uses cofactor (j, i)
        for (int i = 0; i < 3; i++)
            for (int j = 0; j < 3; j++)
                e[i * 3 + j] = divide_sat(cof[j][i], det, clip);
        r.inv_r0c0 = e[0]; r.inv_r0c1 = e[1]; r.inv_r0c2 = e[2];
        r.inv_r1c0 = e[3]; r.inv_r1c1 = e[4]; r.inv_r1c2 = e[5];
        r.inv_r2c0 = e[6]; r.inv_r2c1 = e[7]; r.inv_r2c2 = e[8];
        r.clipped = clip;
        return r;
    endfunction

    function automatic t_mat_in make_matrix(logic [15:0] v[9]);
        t_mat_in m;
        m.m_r0c0 = v[0]; m.m_r0c1 = v[1]; m.m_r0c2 = v[2];
        m.m_r1c0 = v[3]; m.m_r1c1 = v[4]; m.m_r1c2 = v[5];
        m.m_r2c0 = v[6]; m.m_r2c1 = v[7]; m.m_r2c2 = v[8];
        return m;
    endfunction

    function automatic logic [15:0] rand_elem();
        case ($urandom_range(0, 9))
            0: return 16'h8000;
            1: return 16'h7fff;
            2: return 16'($signed($urandom_range(0, 16)) - 8);
            3, 4: return 16'($signed($urandom_range(0, 1024)) - 512);
            5, 6: return 16'($signed($urandom_range(0, 8192)) - 4096);
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic t_mat_in rand_matrix();
        logic [15:0] v[9];
        int          k;
        for (int i = 0; i < 9; i++) v[i] = rand_elem();
        case ($urandom_range(0, 7))
            // singular: duplicate a row or column
            0: begin
                k = $urandom_range(0, 2);
                for (int j = 0; j < 3; j++) v[((k + 1) % 3) * 3 + j] = v[k * 3 + j];
            end
            1: begin
                k = $urandom_range(0, 2);
                for (int i = 0; i < 3; i++) v[i * 3 + (k + 1) % 3] = v[i * 3 + k];
            end
            // near-diagonal: off-diagonal elements kept small
            2, 3: begin
                for (int i = 0; i < 9; i++)
                    if (i % 4 != 0) v[i] = 16'($signed($urandom_range(0, 64)) - 32);
            end
            default: ;
        endcase
        return make_matrix(v);
    endfunction

    task automatic push_diag(logic [15:0] d0, logic [15:0] d1, logic [15:0] d2);
        logic [15:0] v[9];
        for (int i = 0; i < 9; i++) v[i] = 16'h0;
        v[0] = d0; v[4] = d1; v[8] = d2;
        mat_queue.push_back(make_matrix(v));
    endtask

    initial begin
        logic [15:0] v[9];
        push_diag(16'h0100, 16'h0100, 16'h0100);
        push_diag(16'h0200, 16'hff00, 16'h0080);
        push_diag(16'h0001, 16'h0001, 16'h0001);
        push_diag(16'h7fff, 16'h7fff, 16'h7fff);
        push_diag(16'h8000, 16'h8000, 16'h8000);
        push_diag(16'h8000, 16'h7fff, 16'h0001);
        push_diag(16'h0000, 16'h0100, 16'h0100);
        push_diag(16'hffff, 16'hffff, 16'hffff);
        push_diag(16'h0010, 16'h1000, 16'h0100);
        for (int i = 0; i < 9; i++) v[i] = 16'h0;
        mat_queue.push_back(make_matrix(v));
        for (int i = 0; i < 9; i++) v[i] = 16'hffff;
        mat_queue.push_back(make_matrix(v));
        for (int i = 0; i < 9; i++) v[i] = 16'h8000;
        mat_queue.push_back(make_matrix(v));
        for (int i = 0; i < 9; i++) v[i] = 16'h7fff;
        mat_queue.push_back(make_matrix(v));
        for (int i = 0; i < 9; i++) v[i] = (i % 2) ? 16'h8000 : 16'h7fff;
        mat_queue.push_back(make_matrix(v));
        // permutation matrix, negative determinant
        for (int i = 0; i < 9; i++) v[i] = 16'h0;
        v[1] = 16'h0100; v[3] = 16'h0100; v[8] = 16'h0100;
        mat_queue.push_back(make_matrix(v));
        for (int i = 0; i < 9; i++) v[i] = 16'(i + 1) << 8;
        mat_queue.push_back(make_matrix(v));
        while (mat_queue.size() < DIRECTED_N) mat_queue.push_back(rand_matrix());
        for (int n = 0; n < RANDOM_N; n++) mat_queue.push_back(rand_matrix());
        stim_done = 1'b1;
    end

    // driver: bursts of back-to-back starts separated by random gaps
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_start <= 1'b0;
        end else if (!(i_start && o_busy)) begin
            // drop the accepted beat so the front of the queue is the next one
            if (i_start) void'(mat_queue.pop_front());
            if (gap_left > 0) begin
                gap_left <= gap_left - 1;
                i_start <= 1'b0;
            end else if (mat_queue.size() > 0) begin
                i_start <= 1'b1;
                i_mat <= mat_queue[0];
                if (burst_left == 0) begin
                    burst_left <= $urandom_range(1, 30);
                    gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
                end else begin
                    burst_left <= burst_left - 1;
                end
            end else begin
                i_start <= 1'b0;
            end
            if (i_start) inverse_queue.push_back(invert_matrix(i_mat));
        end
    end

    task automatic check_field(string name, logic [15:0] exp_v, logic [15:0] act_v);
        if (exp_v !== act_v) begin
            $error("%s expected %0d actual %0d", name, $signed(exp_v), $signed(act_v));
            error_count++;
        end
    endtask

    always @(posedge i_clk) begin
        t_mat_out exp_r;
        if (i_rst_n && o_valid) begin
            if (inverse_queue.size() == 0) begin
                $error("result with no matrix outstanding");
                error_count++;
            end else begin
                exp_r = inverse_queue.pop_front();
                check_field("inv_r0c0", exp_r.inv_r0c0, o_res.inv_r0c0);
                check_field("inv_r0c1", exp_r.inv_r0c1, o_res.inv_r0c1);
                check_field("inv_r0c2", exp_r.inv_r0c2, o_res.inv_r0c2);
                check_field("inv_r1c0", exp_r.inv_r1c0, o_res.inv_r1c0);
                check_field("inv_r1c1", exp_r.inv_r1c1, o_res.inv_r1c1);
                check_field("inv_r1c2", exp_r.inv_r1c2, o_res.inv_r1c2);
                check_field("inv_r2c0", exp_r.inv_r2c0, o_res.inv_r2c0);
                check_field("inv_r2c1", exp_r.inv_r2c1, o_res.inv_r2c1);
                check_field("inv_r2c2", exp_r.inv_r2c2, o_res.inv_r2c2);
                check_field("singular", 16'(exp_r.singular), 16'(o_res.singular));
                check_field("clipped", 16'(exp_r.clipped), 16'(o_res.clipped));
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        wait (stim_done);
        while (mat_queue.size() != 0 || i_start) @(posedge i_clk);
        while (inverse_queue.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (error_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
src/mi3_pkg.sv
src/mi3_div_lane.sv
src/mi3_cofactor.sv
src/matrix_inverse_3x3_core.sv
src/mi3_checker.sv
dv/tb_matrix_inverse_3x3_core.sv
